/* hdl/gap_buffer_text_store_macros.svh */
// ----------------------------------------------------------------------------
// Gap buffer text store: assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_STORE_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBTS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/gbts_pkg.sv */
// ----------------------------------------------------------------------------
// Gap buffer text store: shared package
// Sizes, operation codes, surrogate ranges and the memory request bundle.
// ----------------------------------------------------------------------------
package gbts_pkg;

	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int POS_W    = ADDR_W + 1;
	localparam int UNIT_W   = 16;
	localparam int OP_W     = 3;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
	localparam logic [OP_W-1:0] OP_PREV   = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	localparam logic [UNIT_W-1:0] HIGH_SUR_LO = 16'hD800;
	localparam logic [UNIT_W-1:0] HIGH_SUR_HI = 16'hDBFF;
	localparam logic [UNIT_W-1:0] LOW_SUR_LO  = 16'hDC00;
	localparam logic [UNIT_W-1:0] LOW_SUR_HI  = 16'hDFFF;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [UNIT_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	function automatic logic is_high(input logic [UNIT_W-1:0] u);
		return (u >= HIGH_SUR_LO) && (u <= HIGH_SUR_HI);
	endfunction

	function automatic logic is_low(input logic [UNIT_W-1:0] u);
		return (u >= LOW_SUR_LO) && (u <= LOW_SUR_HI);
	endfunction

endpackage

/* hdl/gbts_mem.sv */
// ----------------------------------------------------------------------------
// Gap buffer text store: unit memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbts_mem (
	input  logic                              clk,
	input  gbts_pkg::mem_req_t                req,
	output logic [gbts_pkg::UNIT_W-1:0]       rd_data
);
	import gbts_pkg::*;

	logic [UNIT_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

/* hdl/gap_buffer_text_store.sv */
// Flow: one item at a time, the next taken once the result register is loaded;
// the gap move copies one unit at a time through the single port pair.
// Reset: asynchronous, leaves an empty document; memory is not cleared, as cells
// outside the document are never returned, so no clearing pass is run.
`include "gap_buffer_text_store_macros.svh"
// ----------------------------------------------------------------------------
// Gap buffer text store: top level
// Sequencer over a single unit memory that edits and reads a UTF-16 document.
// ----------------------------------------------------------------------------
module gap_buffer_text_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [gbts_pkg::OP_W-1:0]         opcode,
	input  logic [gbts_pkg::POS_W-1:0]        position,
	input  logic [gbts_pkg::POS_W-1:0]        range_end,
	input  logic [gbts_pkg::UNIT_W-1:0]       unit_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              ok,
	output logic [gbts_pkg::UNIT_W-1:0]       unit_out,
	output logic [gbts_pkg::POS_W-1:0]        scalar_position,
	output logic [gbts_pkg::POS_W-1:0]        doc_length
);
	import gbts_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MOVE,
		ST_MOVE_WR,
		ST_INSERT,
		ST_ERASE,
		ST_RD_ISSUE,
		ST_RD_USE,
		ST_FINISH
	} state_t;

	localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  rend_q;
	logic [UNIT_W-1:0] unit_q;
	logic [POS_W-1:0]  gs_q;
	logic [POS_W-1:0]  ge_q;
	logic [POS_W-1:0]  len_q;
	logic [POS_W-1:0]  rd_pos_q;
	logic              in_doc_q;
	logic              phase_q;
	logic [POS_W-1:0]  spos_q;
	logic              res_ok_q;
	logic [UNIT_W-1:0] res_unit_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [UNIT_W-1:0] unit_out_q;
	logic [POS_W-1:0]  spos_out_q;
	logic [POS_W-1:0]  len_out_q;

	mem_req_t          mem_req;
	logic [UNIT_W-1:0] rd_data;
	logic [POS_W-1:0]  gap_size;
	logic [POS_W-1:0]  phys;
	logic [UNIT_W-1:0] rd_unit;
	logic [POS_W-1:0]  erase_n;
	logic              move_left;

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign ok              = ok_q;
	assign unit_out        = unit_out_q;
	assign scalar_position = spos_out_q;
	assign doc_length      = len_out_q;

	// Logical to physical mapping: positions at or past the gap skip over it.
	assign gap_size  = ge_q - gs_q;
	assign phys      = (rd_pos_q < gs_q) ? rd_pos_q : rd_pos_q + gap_size;
	assign rd_unit   = in_doc_q ? rd_data : '0;
	assign erase_n   = rend_q - pos_q;
	assign move_left = (gs_q > pos_q);

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_MOVE: begin
				if (gs_q != ge_q && gs_q != pos_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = move_left ? ADDR_W'(gs_q - 1'b1) : ge_q[ADDR_W-1:0];
				end
			end
			ST_MOVE_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = move_left ? ADDR_W'(ge_q - 1'b1) : gs_q[ADDR_W-1:0];
				mem_req.wr_data = rd_data;
			end
			ST_INSERT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = gs_q[ADDR_W-1:0];
				mem_req.wr_data = unit_q;
			end
			ST_RD_ISSUE: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = phys[ADDR_W-1:0];
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	gbts_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			pos_q       <= '0;
			rend_q      <= '0;
			unit_q      <= '0;
			gs_q        <= '0;
			ge_q        <= CAP_POS;
			len_q       <= '0;
			rd_pos_q    <= '0;
			in_doc_q    <= 1'b0;
			phase_q     <= 1'b0;
			spos_q      <= '0;
			res_ok_q    <= 1'b0;
			res_unit_q  <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			unit_out_q  <= '0;
			spos_out_q  <= '0;
			len_out_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						pos_q   <= position;
						rend_q  <= range_end;
						unit_q  <= unit_in;
						phase_q <= 1'b0;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					res_ok_q   <= 1'b0;
					res_unit_q <= '0;
					spos_q     <= '0;
					rd_pos_q   <= pos_q;
					case (op_q)
						OP_INSERT: begin
							if (pos_q <= len_q && len_q < CAP_POS) begin
								state_q <= ST_MOVE;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						OP_ERASE: begin
							if (pos_q <= rend_q && rend_q <= len_q) begin
								res_ok_q <= 1'b1;
								state_q  <= (pos_q != rend_q) ? ST_MOVE : ST_FINISH;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						OP_READ: begin
							res_ok_q <= 1'b1;
							state_q  <= ST_RD_ISSUE;
						end
						OP_NEXT: begin
							res_ok_q <= 1'b1;
							if (pos_q >= len_q) begin
								spos_q  <= len_q;
								state_q <= ST_FINISH;
							end else begin
								spos_q  <= pos_q + 1'b1;
								state_q <= ST_RD_ISSUE;
							end
						end
						OP_PREV: begin
							res_ok_q <= 1'b1;
							if (pos_q == '0) begin
								state_q <= ST_FINISH;
							end else begin
								spos_q   <= pos_q - 1'b1;
								rd_pos_q <= pos_q - 1'b1;
								state_q  <= ST_RD_ISSUE;
							end
						end
						OP_CLEAR: begin
							res_ok_q <= 1'b1;
							gs_q     <= '0;
							ge_q     <= CAP_POS;
							len_q    <= '0;
							state_q  <= ST_FINISH;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_MOVE: begin
					// A full buffer has no gap to carry, so only the indices move.
					if (gs_q == ge_q) begin
						gs_q    <= pos_q;
						ge_q    <= pos_q;
						state_q <= (op_q == OP_INSERT) ? ST_INSERT : ST_ERASE;
					end else if (gs_q == pos_q) begin
						state_q <= (op_q == OP_INSERT) ? ST_INSERT : ST_ERASE;
					end else begin
						state_q <= ST_MOVE_WR;
					end
				end
				ST_MOVE_WR: begin
					if (move_left) begin
						gs_q <= gs_q - 1'b1;
						ge_q <= ge_q - 1'b1;
					end else begin
						gs_q <= gs_q + 1'b1;
						ge_q <= ge_q + 1'b1;
					end
					state_q <= ST_MOVE;
				end
				ST_INSERT: begin
					gs_q     <= gs_q + 1'b1;
					len_q    <= len_q + 1'b1;
					res_ok_q <= 1'b1;
					state_q  <= ST_FINISH;
				end
				ST_ERASE: begin
					ge_q    <= ge_q + erase_n;
					len_q   <= len_q - erase_n;
					state_q <= ST_FINISH;
				end
				ST_RD_ISSUE: begin
					in_doc_q <= (rd_pos_q < len_q);
					state_q  <= ST_RD_USE;
				end
				ST_RD_USE: begin
					state_q <= ST_FINISH;
					case (op_q)
						OP_READ: begin
							res_unit_q <= rd_unit;
						end
						OP_NEXT: begin
							if (!phase_q) begin
								if (is_high(rd_unit) && spos_q < len_q) begin
									rd_pos_q <= spos_q;
									phase_q  <= 1'b1;
									state_q  <= ST_RD_ISSUE;
								end
							end else if (is_low(rd_unit)) begin
								spos_q <= spos_q + 1'b1;
							end
						end
						OP_PREV: begin
							if (!phase_q) begin
								if (is_low(rd_unit) && spos_q != '0) begin
									rd_pos_q <= spos_q - 1'b1;
									phase_q  <= 1'b1;
									state_q  <= ST_RD_ISSUE;
								end
							end else if (is_high(rd_unit)) begin
								spos_q <= spos_q - 1'b1;
							end
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_FINISH: begin
					// The result register is reloaded only once the previous transfer is taken.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						ok_q        <= res_ok_q;
						unit_out_q  <= res_unit_q;
						spos_out_q  <= spos_q;
						len_out_q   <= len_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`GBTS_ASSERT_SAME(a_gap_order, 1'b1, gs_q <= ge_q, "gap start beyond gap stop")
	`GBTS_ASSERT_SAME(a_len_consistent, state_q == ST_IDLE,
		(POS_W+1)'(len_q) + (POS_W+1)'(ge_q) == (POS_W+1)'(gs_q) + (POS_W+1)'(CAPACITY),
		"length disagrees with gap indices")
	`GBTS_ASSERT_SAME(a_insert_room, state_q == ST_INSERT, gs_q < ge_q, "insert with no gap")
	`GBTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"input accepted while an item is in progress")

endmodule

/* sim/gap_buffer_text_store_checker.sv */
// ----------------------------------------------------------------------------
// Gap buffer text store: result checker
// Watches both channels of the text store, keeps its own copy of the
// document and the gap, works out the reply to every accepted operation
// and compares each reply field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
module text_store_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [gbts_pkg::OP_W-1:0]   opcode,
	input  logic [gbts_pkg::POS_W-1:0]  position,
	input  logic [gbts_pkg::POS_W-1:0]  range_end,
	input  logic [gbts_pkg::UNIT_W-1:0] unit_in,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        ok,
	input  logic [gbts_pkg::UNIT_W-1:0] unit_out,
	input  logic [gbts_pkg::POS_W-1:0]  scalar_position,
	input  logic [gbts_pkg::POS_W-1:0]  doc_length,
	output int                          fail_count,
	output int                          pending
);
	import gbts_pkg::*;

	typedef struct packed {
		logic              done;
		logic [UNIT_W-1:0] code;
		logic [POS_W-1:0]  step_pos;
		logic [POS_W-1:0]  len_after;
	} reply_t;

	logic [UNIT_W-1:0] cells [CAPACITY];
	int gap_lo;
	int gap_hi;
	int doc_len;
	int mismatches = 0;
	int waiting = 0;
	reply_t expected_replies [$];

	assign fail_count = mismatches;
	assign pending    = waiting;

	function automatic logic lead_half(input logic [UNIT_W-1:0] u);
		return u >= HIGH_SUR_LO && u <= HIGH_SUR_HI;
	endfunction

	function automatic logic trail_half(input logic [UNIT_W-1:0] u);
		return u >= LOW_SUR_LO && u <= LOW_SUR_HI;
	endfunction

	function automatic logic [UNIT_W-1:0] unit_at_pos(input int p);
		int phys;
		if (p >= doc_len)
			return '0;
		phys = (p < gap_lo) ? p : p + (gap_hi - gap_lo);
		if (phys >= CAPACITY)
			return '0;
		return cells[phys];
	endfunction

	// Every cell the gap passes over is left at zero.
	function automatic void slide_gap(input int p);
		if (gap_lo == gap_hi) begin
			gap_lo = p;
			gap_hi = p;
			return;
		end
		while (gap_lo > p) begin
			gap_lo--;
			gap_hi--;
			cells[gap_hi] = cells[gap_lo];
			cells[gap_lo] = '0;
		end
		while (gap_lo < p && gap_hi < CAPACITY) begin
			cells[gap_lo] = cells[gap_hi];
			cells[gap_hi] = '0;
			gap_lo++;
			gap_hi++;
		end
	endfunction

	function automatic void wipe_text();
		foreach (cells[i])
			cells[i] = '0;
		gap_lo  = 0;
		gap_hi  = CAPACITY;
		doc_len = 0;
	endfunction

	function automatic reply_t edit_outcome(input logic [OP_W-1:0] op, input int p,
			input int e, input logic [UNIT_W-1:0] code);
		reply_t r;
		int n;
		int s;
		r = '0;
		case (op)
			OP_INSERT: begin
				if (p <= doc_len && doc_len < CAPACITY) begin
					slide_gap(p);
					if (gap_lo < gap_hi) begin
						cells[gap_lo] = code;
						gap_lo++;
						doc_len++;
						r.done = 1'b1;
					end
				end
			end
			OP_ERASE: begin
				if (p <= e && e <= doc_len) begin
					r.done = 1'b1;
					if (p != e) begin
						n = e - p;
						slide_gap(p);
						for (int i = 0; i < n && gap_hi < CAPACITY; i++) begin
							cells[gap_hi] = '0;
							gap_hi++;
						end
						doc_len -= n;
					end
				end
			end
			OP_READ: begin
				r.done = 1'b1;
				r.code = unit_at_pos(p);
			end
			OP_NEXT: begin
				r.done = 1'b1;
				if (p >= doc_len) begin
					s = doc_len;
				end else begin
					s = p + 1;
					if (lead_half(unit_at_pos(p)) && s < doc_len
							&& trail_half(unit_at_pos(s)))
						s++;
				end
				r.step_pos = POS_W'(s);
			end
			OP_PREV: begin
				r.done = 1'b1;
				s = 0;
				if (p != 0) begin
					s = p - 1;
					if (trail_half(unit_at_pos(s)) && s != 0
							&& lead_half(unit_at_pos(s - 1)))
						s--;
				end
				r.step_pos = POS_W'(s);
			end
			OP_CLEAR: begin
				wipe_text();
				r.done = 1'b1;
			end
			default: begin
			end
		endcase
		r.len_after = POS_W'(doc_len);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			wipe_text();
			expected_replies.delete();
			waiting <= 0;
		end else begin
			// The reply leaving on this edge always belongs to an older transfer
			// than the one arriving, so it is handled first.
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply transfer with no operation outstanding");
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					check_field("ok", want.done, ok);
					check_field("unit_out", want.code, unit_out);
					check_field("scalar_position", want.step_pos, scalar_position);
					check_field("doc_length", want.len_after, doc_length);
				end
			end
			if (in_valid && in_ready)
				expected_replies.push_back(edit_outcome(opcode, position, range_end,
					unit_in));
			waiting <= expected_replies.size();
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Gap buffer text store: testbench top
// Drives editing operations into the text store with random gaps on both
// channels: a directed opening, mostly local random editing with surrogate
// pairs, and a short closing run that empties and clears the store. The
// checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module testbench;
	import gbts_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   opcode = '0;
	logic [POS_W-1:0]  position = '0;
	logic [POS_W-1:0]  range_end = '0;
	logic [UNIT_W-1:0] unit_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              ok;
	logic [UNIT_W-1:0] unit_out;
	logic [POS_W-1:0]  scalar_position;
	logic [POS_W-1:0]  doc_length;
	int                fail_count;
	int                pending;

	int doc_guess = 0;
	int caret = 0;
	int sent = 0;
	int hold_requests = 0;
	bit eager = 1'b0;

	always #6 clk = ~clk;

	gap_buffer_text_store uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.position(position),
		.range_end(range_end),
		.unit_in(unit_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.unit_out(unit_out),
		.scalar_position(scalar_position),
		.doc_length(doc_length)
	);

	text_store_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.position(position),
		.range_end(range_end),
		.unit_in(unit_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.unit_out(unit_out),
		.scalar_position(scalar_position),
		.doc_length(doc_length),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Surrogate halves turn up far more often than in uniform data.
	function automatic logic [UNIT_W-1:0] pick_unit();
		case ($urandom_range(0, 3))
			0: return UNIT_W'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI));
			1: return UNIT_W'($urandom_range(LOW_SUR_LO, LOW_SUR_HI));
			default: return UNIT_W'($urandom);
		endcase
	endfunction

	// The length is followed only to aim positions at the document.
	task automatic push_item(input logic [OP_W-1:0] op, input int pos, input int rend,
			input logic [UNIT_W-1:0] code);
		int idle;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] e;
		idle = eager ? 0 : pick_gap();
		p = POS_W'(pos);
		e = POS_W'(rend);
		if (idle > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		opcode    <= op;
		position  <= p;
		range_end <= e;
		unit_in   <= code;
		do @(posedge clk); while (!in_ready);
		sent++;
		case (op)
			OP_INSERT: if (p <= doc_guess && doc_guess < CAPACITY) doc_guess++;
			OP_ERASE: if (p <= e && e <= doc_guess) doc_guess -= e - p;
			OP_CLEAR: doc_guess = 0;
			default: ;
		endcase
		caret = (p > doc_guess) ? doc_guess : p;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int holds_done;
		int idle;
		holds_done = 0;
		@(negedge clk);
		forever begin
			if (hold_requests != holds_done) begin
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
				holds_done++;
			end else begin
				idle = eager ? 0 : pick_gap();
				if (idle > 0) begin
					out_ready <= 1'b0;
					repeat (idle) @(negedge clk);
				end else begin
					out_ready <= 1'b1;
					repeat ($urandom_range(1, 4)) @(negedge clk);
				end
			end
		end
	end

	initial begin
		#24_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		int w;
		int near;
		int lo;
		int n;
		int room;
		bit paused;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Opening: empty document, a surrogate pair, the edges of every step.
		push_item(OP_READ, 0, 0, '0);
		push_item(OP_NEXT, 0, 0, '0);
		push_item(OP_PREV, 0, 0, '0);
		push_item(OP_INSERT, 1, 0, 16'h1234);
		push_item(OP_INSERT, 0, 0, 16'h0000);
		push_item(OP_INSERT, 1, 0, 16'hD83D);
		push_item(OP_INSERT, 2, 0, 16'hDE00);
		push_item(OP_INSERT, 3, 0, 16'hFFFF);
		push_item(OP_INSERT, 0, 0, HIGH_SUR_HI);
		push_item(OP_INSERT, 5, 0, LOW_SUR_LO);
		push_item(OP_READ, 2, 0, '0);
		push_item(OP_READ, 6, 0, '0);
		push_item(OP_READ, 8191, 8191, 16'hFFFF);
		push_item(OP_NEXT, 2, 0, '0);
		push_item(OP_NEXT, 6, 0, '0);
		push_item(OP_NEXT, 8191, 0, '0);
		push_item(OP_PREV, 4, 0, '0);
		push_item(OP_PREV, 6, 0, '0);
		push_item(OP_PREV, 8, 0, '0);
		push_item(OP_ERASE, 3, 1, '0);
		push_item(OP_ERASE, 2, 7, '0);
		push_item(OP_ERASE, 2, 2, '0);
		push_item(OP_ERASE, 1, 3, '0);
		push_item(3'd6, 5, 9, 16'hA5A5);
		push_item(3'd7, 8191, 8191, 16'h5A5A);
		push_item(OP_CLEAR, 0, 0, '0);
		drain();

		// Random editing around a moving caret, with some malformed requests.
		sent = 0;
		while (sent < 1020) begin
			if (sent >= 300 && hold_requests == 0)
				hold_requests++;
			if (sent >= 600 && !paused) begin
				paused = 1'b1;
				drain();
			end
			eager = (sent >= 750 && sent < 850);
			lo = (caret > 3) ? caret - 3 : 0;
			near = lo + $urandom_range(0, 6);
			if (near > doc_guess)
				near = doc_guess;
			if ($urandom_range(0, 9) == 0)
				near = $urandom_range(0, doc_guess);
			w = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 12) begin
				push_item(OP_W'($urandom_range(0, 7)), $urandom_range(0, 8191),
					$urandom_range(0, 8191), UNIT_W'($urandom));
			end else if (w < 40 && doc_guess < 120) begin
				if ($urandom_range(0, 3) == 0) begin
					push_item(OP_INSERT, near, 0,
						UNIT_W'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI)));
					push_item(OP_INSERT, near + 1, 0,
						UNIT_W'($urandom_range(LOW_SUR_LO, LOW_SUR_HI)));
				end else begin
					push_item(OP_INSERT, near, 0, pick_unit());
				end
			end else if (w < 55 || (w < 40 && doc_guess >= 120)) begin
				room = doc_guess - near;
				n = $urandom_range(0, (room < 8) ? room : 8);
				push_item(OP_ERASE, near, near + n, UNIT_W'($urandom));
			end else if (w < 73) begin
				push_item(OP_READ, near + $urandom_range(0, 1), 0, '0);
			end else if (w < 85) begin
				push_item(OP_NEXT, near + $urandom_range(0, 1), 0, '0);
			end else if (w < 98) begin
				push_item(OP_PREV, near + $urandom_range(0, 2), 0, '0);
			end else begin
				push_item(OP_CLEAR, 0, 0, '0);
			end
		end
		eager = 1'b0;
		drain();

		// Closing: erase the whole document, then edit and clear the empty store.
		push_item(OP_ERASE, 0, doc_guess, '0);
		push_item(OP_READ, 0, 0, '0);
		push_item(OP_INSERT, 0, 0, pick_unit());
		push_item(OP_CLEAR, 0, 0, '0);
		push_item(OP_READ, 0, 0, '0);
		drain();

		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
